// ----- design/sed_pkg.sv -----
// shared types and character constants for the string escape decoder
// no dependencies
package sed_pkg;

    typedef struct packed {
        logic [7:0] value;
        logic       has_value;
        logic       last;
        logic       closed;
        logic       error;
    } result_t;

    localparam logic [7:0] CHR_NUL   = 8'h00;
    localparam logic [7:0] CHR_BS    = 8'h08;
    localparam logic [7:0] CHR_TAB   = 8'h09;
    localparam logic [7:0] CHR_LF    = 8'h0A;
    localparam logic [7:0] CHR_FF    = 8'h0C;
    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_DQUOTE = 8'h22;
    localparam logic [7:0] CHR_SQUOTE = 8'h27;
    localparam logic [7:0] CHR_BSLASH = 8'h5C;
    localparam logic [7:0] CHR_LOW_B = 8'h62;
    localparam logic [7:0] CHR_LOW_T = 8'h74;
    localparam logic [7:0] CHR_LOW_N = 8'h6E;
    localparam logic [7:0] CHR_LOW_F = 8'h66;
    localparam logic [7:0] CHR_LOW_R = 8'h72;
    localparam logic [7:0] CHR_LOW_X = 8'h78;
    localparam logic [7:0] CHR_UP_X  = 8'h58;

    function automatic logic is_oct(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h37);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h61) && (c <= 8'h66))
            || ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] t;
        t = 8'h00;
        if (c <= 8'h39) begin
            t = c - 8'h30;
        end else if (c >= 8'h61) begin
            t = c - 8'h57;
        end else begin
            t = c - 8'h37;
        end
        return t[3:0];
    endfunction

endpackage

// ----- design/string_escape_decoder_core.sv -----
// string escape decoder top level: decode step and four-entry result queue
// depends on sed_pkg
//
// channel   | direction | tdata                          | tuser      | tlast
// s_axis    | in        | [7:0] ch, [15:8] delimiter     | -          | -
// m_axis    | out       | [7:0] value, [8] closed, [9] error | has_value | last
//
// one byte is decoded per cycle in the cycle it is accepted
// a byte may yield two results, which leave one per cycle from the queue while m_axis_tready is high
// s_axis_tready is high while at least two queue entries are free
// sustained rate is one byte per cycle unless results outpace output draining
// aresetn clears the decode state and empties the queue
module string_escape_decoder_core
    import sed_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] ch, [15:8] delimiter
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] value, [8] closed, [9] error
    output logic        m_axis_tuser,   // has_value
    output logic        m_axis_tlast
);

    localparam logic [2:0] MODE_PLAIN = 3'd0;
    localparam logic [2:0] MODE_ESC   = 3'd1;
    localparam logic [2:0] MODE_HEX1  = 3'd2;
    localparam logic [2:0] MODE_HEX2  = 3'd3;
    localparam logic [2:0] MODE_OCT2  = 3'd4;
    localparam logic [2:0] MODE_OCT3  = 3'd5;

    logic [2:0] mode_reg, mode_next;
    logic [7:0] acc_reg, acc_next;
    logic       upper_x_reg, upper_x_next;
    logic       err_reg, err_next;

    result_t    queue_reg [4];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] count_reg;

    logic [7:0] ch, delim;
    logic       s_fire, m_fire;
    logic       do_plain;
    result_t    res_a, res_b;
    logic [1:0] num_res;

    assign ch    = s_axis_tdata[7:0];
    assign delim = s_axis_tdata[15:8];
    assign s_axis_tready = (count_reg <= 3'd2);
    assign s_fire = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (count_reg != 3'd0);
    assign m_fire = m_axis_tvalid && m_axis_tready;

    always_comb begin
        result_t flush_res, main_res;
        logic    flush_v, main_v;
        flush_res = '{value: 8'h00, has_value: 1'b1, last: 1'b0, closed: 1'b0,
                      error: err_reg};
        main_res  = flush_res;
        flush_v   = 1'b0;
        main_v    = 1'b0;
        do_plain  = 1'b0;
        mode_next    = mode_reg;
        acc_next     = acc_reg;
        upper_x_next = upper_x_reg;
        err_next     = err_reg;

        unique case (mode_reg) inside
            MODE_ESC: begin
                mode_next = MODE_PLAIN;
                main_v    = 1'b1;
                main_res.value = ch;
                unique case (ch) inside
                    CHR_NUL: begin
                        main_res = '{value: 8'h00, has_value: 1'b0, last: 1'b1,
                                     closed: 1'b0, error: 1'b1};
                    end
                    CHR_LOW_B: main_res.value = CHR_BS;
                    CHR_LOW_T: main_res.value = CHR_TAB;
                    CHR_LOW_N: main_res.value = CHR_LF;
                    CHR_LOW_F: main_res.value = CHR_FF;
                    CHR_LOW_R: main_res.value = CHR_CR;
                    CHR_LOW_X, CHR_UP_X: begin
                        main_v       = 1'b0;
                        upper_x_next = (ch == CHR_UP_X);
                        acc_next     = 8'h00;
                        mode_next    = MODE_HEX1;
                    end
                    default: begin
                        if (is_oct(ch)) begin
                            main_v    = 1'b0;
                            acc_next  = {5'd0, ch[2:0]};
                            mode_next = MODE_OCT2;
                        end
                    end
                endcase
            end
            MODE_HEX1: begin
                if (is_hex(ch)) begin
                    acc_next  = {4'd0, hex_val(ch)};
                    mode_next = MODE_HEX2;
                end else begin
                    flush_v = 1'b1;
                    flush_res.value = upper_x_reg ? CHR_UP_X : CHR_LOW_X;
                    do_plain = 1'b1;
                end
            end
            MODE_HEX2: begin
                if (is_hex(ch)) begin
                    main_v    = 1'b1;
                    main_res.value = {acc_reg[3:0], hex_val(ch)};
                    mode_next = MODE_PLAIN;
                end else begin
                    flush_v = 1'b1;
                    flush_res.value = acc_reg;
                    do_plain = 1'b1;
                end
            end
            MODE_OCT2, MODE_OCT3: begin
                if (is_oct(ch)) begin
                    if (mode_reg == MODE_OCT2) begin
                        acc_next  = {acc_reg[4:0], ch[2:0]};
                        mode_next = MODE_OCT3;
                    end else begin
                        main_v    = 1'b1;
                        main_res.value = {acc_reg[4:0], ch[2:0]};
                        mode_next = MODE_PLAIN;
                    end
                end else begin
                    flush_v = 1'b1;
                    flush_res.value = acc_reg;
                    do_plain = 1'b1;
                end
            end
            default: do_plain = 1'b1;
        endcase

        if (do_plain) begin
            mode_next = MODE_PLAIN;
            if (ch == CHR_NUL || ch == delim) begin
                main_v   = 1'b1;
                main_res = '{value: 8'h00, has_value: 1'b0, last: 1'b1,
                             closed: (ch != CHR_NUL), error: err_reg};
            end else if (ch == CHR_BSLASH) begin
                mode_next = MODE_ESC;
            end else if (ch == CHR_LF || ch == CHR_CR) begin
                err_next = 1'b1;
            end else begin
                main_v = 1'b1;
                main_res.value = ch;
            end
        end

        if (main_v && main_res.last) begin
            mode_next    = MODE_PLAIN;
            acc_next     = 8'h00;
            upper_x_next = 1'b0;
            err_next     = 1'b0;
        end

        res_a   = flush_v ? flush_res : main_res;
        res_b   = main_res;
        num_res = {1'b0, flush_v} + {1'b0, main_v};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_PLAIN;
            acc_reg     <= 8'h00;
            upper_x_reg <= 1'b0;
            err_reg     <= 1'b0;
        end else if (s_fire) begin
            mode_reg    <= mode_next;
            acc_reg     <= acc_next;
            upper_x_reg <= upper_x_next;
            err_reg     <= err_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && num_res != 2'd0) begin
            queue_reg[wr_ptr_reg] <= res_a;
        end
        if (s_fire && num_res == 2'd2) begin
            queue_reg[wr_ptr_reg + 2'd1] <= res_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end else begin
            if (s_fire) begin
                wr_ptr_reg <= wr_ptr_reg + num_res;
            end
            if (m_fire) begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_reg + (s_fire ? {1'b0, num_res} : 3'd0)
                       - {2'd0, m_fire};
        end
    end

    assign m_axis_tdata = {6'd0, queue_reg[rd_ptr_reg].error,
                           queue_reg[rd_ptr_reg].closed, queue_reg[rd_ptr_reg].value};
    assign m_axis_tuser = queue_reg[rd_ptr_reg].has_value;
    assign m_axis_tlast = queue_reg[rd_ptr_reg].last;

endmodule

// ----- sim/tb.sv -----
// testbench for string_escape_decoder_core: string bodies in, decoded bytes and end markers out
// depends on sed_pkg and design/string_escape_decoder_core.sv
// an escape decoder model in a small scoreboard class predicts every output transaction
module tb
    import sed_pkg::*;
();

    typedef enum logic [2:0] {
        SCAN_TEXT,
        SCAN_ESC,
        SCAN_HEX1,
        SCAN_HEX2,
        SCAN_OCT2,
        SCAN_OCT3
    } scan_mode_t;

    class escape_scoreboard;
        scan_mode_t mode;
        logic [7:0] acc;
        logic       upper;
        logic       err_flag;
        bit         at_boundary;
        result_t    decoded_q[$];
        int         errors;

        function new();
            restart();
            at_boundary = 1;
            errors = 0;
        endfunction

        function void restart();
            mode = SCAN_TEXT;
            acc = 8'h00;
            upper = 1'b0;
            err_flag = 1'b0;
        endfunction

        function void push_char(logic [7:0] v);
            result_t r;
            r.value = v;
            r.has_value = 1'b1;
            r.last = 1'b0;
            r.closed = 1'b0;
            r.error = err_flag;
            decoded_q.push_back(r);
        endfunction

        function void push_end(logic by_delim);
            result_t r;
            r.value = 8'h00;
            r.has_value = 1'b0;
            r.last = 1'b1;
            r.closed = by_delim;
            r.error = err_flag;
            decoded_q.push_back(r);
            restart();
            at_boundary = 1;
        endfunction

        function int hex_nibble(logic [7:0] c);
            if (c >= "0" && c <= "9") return int'(c - "0");
            if (c >= "a" && c <= "f") return int'(c - "a") + 10;
            if (c >= "A" && c <= "F") return int'(c - "A") + 10;
            return -1;
        endfunction

        function int oct_nibble(logic [7:0] c);
            if (c >= "0" && c <= "7") return int'(c - "0");
            return -1;
        endfunction

        function void text_byte(logic [7:0] ch, logic [7:0] delim);
            mode = SCAN_TEXT;
            if (ch == CHR_NUL) begin
                push_end(1'b0);
            end else if (ch == delim) begin
                push_end(1'b1);
            end else if (ch == CHR_BSLASH) begin
                mode = SCAN_ESC;
            end else if (ch == CHR_LF || ch == CHR_CR) begin
                err_flag = 1'b1;
            end else begin
                push_char(ch);
            end
        endfunction

        // one accepted input transaction
        function void note_byte(logic [7:0] ch, logic [7:0] delim);
            int d;
            at_boundary = 0;
            case (mode) inside
                SCAN_ESC: begin
                    mode = SCAN_TEXT;
                    case (ch) inside
                        CHR_NUL: begin
                            err_flag = 1'b1;
                            push_end(1'b0);
                        end
                        CHR_LOW_B: push_char(CHR_BS);
                        CHR_LOW_T: push_char(CHR_TAB);
                        CHR_LOW_N: push_char(CHR_LF);
                        CHR_LOW_F: push_char(CHR_FF);
                        CHR_LOW_R: push_char(CHR_CR);
                        CHR_LOW_X, CHR_UP_X: begin
                            upper = (ch == CHR_UP_X);
                            acc = 8'h00;
                            mode = SCAN_HEX1;
                        end
                        default: begin
                            d = oct_nibble(ch);
                            if (d >= 0) begin
                                acc = 8'(d);
                                mode = SCAN_OCT2;
                            end else begin
                                push_char(ch);
                            end
                        end
                    endcase
                end
                SCAN_HEX1: begin
                    d = hex_nibble(ch);
                    if (d >= 0) begin
                        acc = 8'(d);
                        mode = SCAN_HEX2;
                    end else begin
                        push_char(upper ? CHR_UP_X : CHR_LOW_X);
                        text_byte(ch, delim);
                    end
                end
                SCAN_HEX2: begin
                    d = hex_nibble(ch);
                    if (d >= 0) begin
                        mode = SCAN_TEXT;
                        push_char({acc[3:0], 4'(d)});
                    end else begin
                        push_char(acc);
                        text_byte(ch, delim);
                    end
                end
                SCAN_OCT2, SCAN_OCT3: begin
                    d = oct_nibble(ch);
                    if (d >= 0 && mode == SCAN_OCT2) begin
                        acc = (acc << 3) | {5'b0, 3'(d)};
                        mode = SCAN_OCT3;
                    end else if (d >= 0) begin
                        mode = SCAN_TEXT;
                        push_char((acc << 3) | {5'b0, 3'(d)});
                    end else begin
                        push_char(acc);
                        text_byte(ch, delim);
                    end
                end
                default: text_byte(ch, delim);
            endcase
        endfunction

        task report(string what);
            errors++;
            $display("%0t mismatch: %s", $time, what);
        endtask

        // one accepted output transaction
        task check_result(result_t got);
            result_t want;
            if (decoded_q.size() == 0) begin
                report($sformatf("unexpected value=%h has_value=%b last=%b closed=%b error=%b",
                                 got.value, got.has_value, got.last, got.closed, got.error));
                return;
            end
            want = decoded_q.pop_front();
            if (got !== want) begin
                report($sformatf("got value=%h has_value=%b last=%b closed=%b error=%b, %s",
                                 got.value, got.has_value, got.last, got.closed, got.error,
                                 $sformatf("want value=%h has_value=%b last=%b closed=%b error=%b",
                                           want.value, want.has_value, want.last,
                                           want.closed, want.error)));
            end
        endtask
    endclass

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = 16'h0000;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    escape_scoreboard sb = new();
    int src_gap_max = 0;
    int sink_gap_max = 0;
    int bytes_sent = 0;
    string hex_chars = "0123456789abcdefABCDEF";
    string simple_escapes = "btnfr\"'\\";

    string_escape_decoder_core uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    function automatic int pick_gap_max();
        case ($urandom_range(3, 0))
            0: return 0;
            1: return 3;
            default: return 18;
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] ch, input logic [7:0] delim);
        int gap;
        gap = (src_gap_max == 0) ? 0 : $urandom_range(src_gap_max, 0);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {delim, ch};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        sb.note_byte(ch, delim);
        bytes_sent++;
    endtask

    task automatic send_text(input logic [7:0] delim, input string s);
        int i;
        for (i = 0; i < s.len(); i++) send_byte(s[i], delim);
    endtask

    task automatic send_token(input logic [7:0] delim);
        int kind;
        int n;
        logic [7:0] c;
        kind = $urandom_range(99, 0);
        if (kind < 35) begin
            c = 8'($urandom_range(126, 32));
            if (c == delim || c == CHR_BSLASH) c = "a";
            send_byte(c, delim);
        end else if (kind < 50) begin
            send_byte(CHR_BSLASH, delim);
            send_byte(simple_escapes[$urandom_range(simple_escapes.len() - 1, 0)], delim);
        end else if (kind < 60) begin
            send_byte(CHR_BSLASH, delim);
            send_byte($urandom_range(1, 0) ? CHR_UP_X : CHR_LOW_X, delim);
            n = $urandom_range(2, 0);
            repeat (n) send_byte(hex_chars[$urandom_range(hex_chars.len() - 1, 0)], delim);
        end else if (kind < 70) begin
            send_byte(CHR_BSLASH, delim);
            n = $urandom_range(3, 1);
            repeat (n) send_byte(8'("0" + $urandom_range(7, 0)), delim);
        end else if (kind < 77) begin
            send_byte(CHR_BSLASH, delim);
            send_byte(8'($urandom_range(255, 0)), delim);
        end else if (kind < 82) begin
            send_byte($urandom_range(1, 0) ? CHR_CR : CHR_LF, delim);
        end else if (kind < 86) begin
            send_byte(CHR_BSLASH, delim);
            case ($urandom_range(3, 0))
                0: send_byte(CHR_CR, delim);
                1: send_byte(CHR_LF, delim);
                2: send_byte("9", delim);
                default: send_byte(delim, delim);
            endcase
        end else begin
            send_byte(8'($urandom_range(255, 0)), delim);
        end
    endtask

    task automatic send_random_string();
        logic [7:0] delim;
        int n_tokens;
        case ($urandom_range(9, 0)) inside
            0, 1, 2, 3, 4, 5: delim = CHR_DQUOTE;
            6, 7: delim = CHR_SQUOTE;
            default: delim = 8'($urandom_range(255, 0));
        endcase
        src_gap_max = pick_gap_max();
        n_tokens = $urandom_range(10, 0);
        repeat (n_tokens) send_token(delim);
        case ($urandom_range(9, 0)) inside
            7, 8: send_byte(CHR_NUL, delim);
            9: begin
                send_byte(CHR_BSLASH, delim);
                send_byte(CHR_NUL, delim);
            end
            default: send_byte(delim, delim);
        endcase
        // a trailing escape digit may have swallowed the terminator
        if (!sb.at_boundary) send_byte(CHR_NUL, delim);
    endtask

    // output side: random stalls, check every transaction
    initial begin
        int gap;
        int seen;
        result_t got;
        seen = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (seen % 32 == 0) sink_gap_max = pick_gap_max();
            gap = (sink_gap_max == 0) ? 0 : $urandom_range(sink_gap_max, 0);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            @(posedge aclk);
            while (!m_axis_tvalid) @(posedge aclk);
            got.value = m_axis_tdata[7:0];
            got.has_value = m_axis_tuser;
            got.last = m_axis_tlast;
            got.closed = m_axis_tdata[8];
            got.error = m_axis_tdata[9];
            sb.check_result(got);
            seen++;
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // hex flush with one digit, upper X without digits, octal 377 and wrap, escaped 9
        send_text(CHR_DQUOTE, "\\x4g\\XZ\\377\\400\\9");
        send_byte(8'hFF, CHR_DQUOTE);
        send_byte(CHR_CR, CHR_DQUOTE);
        send_byte(CHR_DQUOTE, CHR_DQUOTE);
        // zero delimiter is end of input
        send_byte("A", CHR_NUL);
        send_byte(CHR_NUL, CHR_NUL);
        // backslash as delimiter closes the string
        send_byte(CHR_BSLASH, CHR_BSLASH);
        // dangling backslash
        send_byte(CHR_BSLASH, 8'hFF);
        send_byte(CHR_NUL, 8'hFF);

        while (bytes_sent < 825) send_random_string();
        s_axis_tvalid <= 1'b0;

        while (sb.decoded_q.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #12000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
